@@ design/upq_pkg.sv @@
// ----------------------------------------------------------------------------
// upq_pkg
// Shared types and constants of the unsorted priority queue: request and
// status codes, configuration register index and stream packing widths.
// ----------------------------------------------------------------------------
package upq_pkg;

  // Request kinds carried in the input tuser bit.
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status carried in the output tuser bits.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Configuration port: registers sit 4 bytes apart, paddr[2] picks one.
  localparam int   CFG_ADDR_W       = 3;
  localparam int   CFG_DATA_W       = 32;
  localparam logic CFG_IDX_ORDER    = 1'b0;

  // Fixed field widths of the stream payloads.
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_COUNT_W = 5;
  localparam int OUT_PAD_W   = 3;
  localparam int OUT_TDATA_W = OUT_VALUE_W + OUT_COUNT_W + OUT_PAD_W;

  // Control of the maximum tracker during a scan.
  typedef struct packed {
    logic valid;  // a stored entry is presented this cycle
    logic first;  // the entry is the first of the scan
  } scan_ctl_t;

endpackage

@@ design/upq_max_track.sv @@
// ----------------------------------------------------------------------------
// upq_max_track
// Running maximum over the entries presented during a dequeue scan. Keeps
// the earliest of equal maxima and compares unsigned or two's complement.
// ----------------------------------------------------------------------------
module upq_max_track #(
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 4
) (
  input  logic                  clk,
  input  upq_pkg::scan_ctl_t    ctl,
  input  logic                  order_signed,
  input  logic [VALUE_WIDTH-1:0] data,
  input  logic [IDX_W-1:0]      idx,
  output logic [VALUE_WIDTH-1:0] best_val,
  output logic [IDX_W-1:0]      sel_idx
);
  import upq_pkg::*;

  logic [VALUE_WIDTH-1:0] best_val_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [VALUE_WIDTH-1:0] flip;
  logic [VALUE_WIDTH-1:0] key_new;
  logic [VALUE_WIDTH-1:0] key_best;
  logic                   take;

  // Flipping the sign bit turns a signed order into an unsigned one.
  always_comb begin
    flip = '0;
    flip[VALUE_WIDTH-1] = order_signed;
    key_new  = data ^ flip;
    key_best = best_val_r ^ flip;
    take     = ctl.first || (key_new > key_best);
    sel_idx  = take ? idx : best_idx_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && take) begin
      best_val_r <= data;
      best_idx_r <= idx;
    end
  end

  assign best_val = best_val_r;

endmodule

@@ design/unsorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// unsorted_priority_queue
// Priority queue of up to DEPTH values kept in arrival order in one memory.
// ----------------------------------------------------------------------------
// An enqueue, and a dequeue from an empty queue, reach the output register
// in the cycle after they are accepted. A dequeue of a queue holding n
// values scans all n entries for the maximum, one memory read per cycle, then
// the entries behind the removed one are moved down one place, read and
// written back one a cycle, and finally S_DONE hands the result to the output
// register once it is free. The single read port of the entry memory is why entries are read one at a time.
// The next item is accepted only while the block itself is idle and the
// output register is either empty or has its result taken in that same
// cycle; a result that waits on a stalled output holds the input off. No
// clearing pass is needed after reset: only entries below the stored count
// are ever read.
module unsorted_priority_queue #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input item stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [upq_pkg::IN_VALUE_W-1:0]    in_tdata,    // [31:0] value_in
  input  logic [0:0]                        in_tuser,    // [0] req_type
  // Result item stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [upq_pkg::OUT_TDATA_W-1:0]   out_tdata,   // [31:0] value_out,
                                                         // [36:32] entry_count
  output logic [1:0]                        out_tuser,   // [1:0] status
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [upq_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [upq_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [upq_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import upq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]          scan_idx_r, scan_idx_nxt;
  logic                   wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]          wr_addr_r, wr_addr_nxt;
  logic                   order_signed_r;

  logic [VALUE_WIDTH-1:0] entry_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  logic                   out_valid_r;
  status_t                out_status_r, out_status_nxt;
  logic [OUT_VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                   out_load;
  logic                   out_free;

  logic                   in_fire;
  logic [VALUE_WIDTH-1:0] in_val;
  scan_ctl_t              scan_ctl;
  logic [VALUE_WIDTH-1:0] best_val;
  logic [AW-1:0]          sel_idx;
  logic                   cfg_wr;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign in_val    = VALUE_WIDTH'(in_tdata);

  upq_max_track #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (AW)
  ) u_max (
    .clk          (clk),
    .ctl          (scan_ctl),
    .order_signed (order_signed_r),
    .data         (rd_data_r),
    .idx          (scan_idx_r),
    .best_val     (best_val),
    .sel_idx      (sel_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    scan_idx_nxt   = scan_idx_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    rd_en          = 1'b0;
    rd_addr        = rd_ptr_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_data        = in_val;
    out_load       = 1'b0;
    out_status_nxt = ST_OK;
    out_value_nxt  = '0;
    out_count_nxt  = OUT_COUNT_W'(count_r);
    scan_ctl       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == REQ_ENQ) begin
            out_load = 1'b1;
            if (count_r == CW'(DEPTH)) begin
              out_status_nxt = ST_FULL;
            end else begin
              wr_en         = 1'b1;
              count_nxt     = count_r + CW'(1);
              out_count_nxt = OUT_COUNT_W'(count_r + CW'(1));
            end
          end else if (count_r == '0) begin
            out_load       = 1'b1;
            out_status_nxt = ST_EMPTY;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = '0;
            rd_ptr_nxt   = CW'(1);
            scan_idx_nxt = '0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read data of entry scan_idx_r arrives now; the next read overlaps.
        scan_ctl.valid = 1'b1;
        scan_ctl.first = (scan_idx_r == '0);
        scan_idx_nxt   = scan_idx_r + AW'(1);
        if (rd_ptr_r < count_r) begin
          rd_en      = 1'b1;
          rd_ptr_nxt = rd_ptr_r + CW'(1);
        end
        if (CW'(scan_idx_r) == count_r - CW'(1)) begin
          if (CW'(sel_idx) == count_r - CW'(1)) begin
            state_nxt = S_DONE;
          end else begin
            rd_ptr_nxt = CW'(sel_idx) + CW'(1);
            state_nxt  = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // Entry i+1 is read, then written to place i the next cycle.
        if (rd_ptr_r < count_r) begin
          rd_en       = 1'b1;
          rd_ptr_nxt  = rd_ptr_r + CW'(1);
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = AW'(rd_ptr_r - CW'(1));
        end else begin
          state_nxt = S_DONE;
        end
        if (wr_pend_r) begin
          wr_en   = 1'b1;
          wr_addr = wr_addr_r;
          wr_data = rd_data_r;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_value_nxt = OUT_VALUE_W'(best_val);
          count_nxt     = count_r - CW'(1);
          out_count_nxt = OUT_COUNT_W'(count_r - CW'(1));
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    scan_idx_r <= scan_idx_nxt;
    wr_addr_r  <= wr_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_count_r, out_value_r};
  assign out_tuser  = out_status_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_signed_r <= 1'b0;
    end else if (cfg_wr && (cfg_paddr[2] == CFG_IDX_ORDER)) begin
      order_signed_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_ORDER) ?
                      CFG_DATA_W'(order_signed_r) : '0;

endmodule

@@ design/upq_chk.sv @@
// ----------------------------------------------------------------------------
// upq_chk
// Port-level checks of the unsorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module upq_chk #(
  parameter int DEPTH = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [upq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);
  import upq_pkg::*;

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An empty dequeue reports no value and an empty queue.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> (out_tdata == '0))
    else $error("empty status with nonzero value or count");

  // A refused enqueue reports a full queue and no value.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |->
      (out_tdata[36:32] == OUT_COUNT_W'(DEPTH)) && (out_tdata[31:0] == '0))
    else $error("full status with wrong count or nonzero value");

  // No result is pending right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind unsorted_priority_queue upq_chk #(.DEPTH(DEPTH)) u_upq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/upq_checker.sv @@
// ----------------------------------------------------------------------------
// upq_checker
// Watches the request, result and configuration ports of the unsorted priority
// queue, keeps its own copy of the stored values and compare order, predicts
// one result per accepted request and compares results field by field.
// ----------------------------------------------------------------------------
module upq_checker #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [upq_pkg::IN_VALUE_W-1:0]  in_tdata,    // [31:0] value_in
  input  logic [0:0]                      in_tuser,    // [0] req_type
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [upq_pkg::OUT_TDATA_W-1:0] out_tdata,   // [31:0] value_out,
                                                       // [36:32] entry_count
  input  logic [1:0]                      out_tuser,   // [1:0] status
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic                            cfg_pready,
  input  logic [upq_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [upq_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output int                              errors,
  output int                              pending,
  output int                              checked
);
  import upq_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic [OUT_VALUE_W-1:0]   value;
    logic [OUT_COUNT_W-1:0]   count;
  } queue_result_t;

  queue_result_t          expected_results[$];
  logic [IN_VALUE_W-1:0]  stored_values[DEPTH];
  int                     stored_count;
  logic                   compare_signed;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s is %0h, expected %0h", checked, field, got, want);
    errors++;
  endtask

  // Applies one request to the local copy of the queue and returns its result.
  function automatic queue_result_t predict_request(input logic req,
                                                    input logic [IN_VALUE_W-1:0] value);
    queue_result_t          res;
    int                     best;
    logic [IN_VALUE_W-1:0]  flip;
    res.status = ST_OK;
    res.value  = '0;
    // Flipping the sign bit turns a signed order into an unsigned one.
    flip = compare_signed ? {1'b1, {(IN_VALUE_W-1){1'b0}}} : '0;
    if (req == REQ_ENQ) begin
      if (stored_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        stored_values[stored_count] = value;
        stored_count++;
      end
    end else if (stored_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < stored_count; i++) begin
        if ((stored_values[i] ^ flip) > (stored_values[best] ^ flip)) best = i;
      end
      res.value = stored_values[best];
      for (int i = best; i < stored_count - 1; i++) stored_values[i] = stored_values[i + 1];
      stored_count--;
    end
    res.count = OUT_COUNT_W'(stored_count);
    return res;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      stored_count   = 0;
      compare_signed = 1'b0;
      errors         = 0;
      checked        = 0;
      expected_results.delete();
    end else begin
      // Results are checked before this edge's request is added, since a
      // request never produces its result in the cycle it is accepted.
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, value", out_tdata[OUT_VALUE_W-1:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", 32'(out_tuser), 32'(want.status));
          if (out_tdata[OUT_VALUE_W-1:0] !== want.value)
            report_mismatch("value_out", out_tdata[OUT_VALUE_W-1:0], want.value);
          if (out_tdata[OUT_VALUE_W +: OUT_COUNT_W] !== want.count)
            report_mismatch("entry_count", 32'(out_tdata[OUT_VALUE_W +: OUT_COUNT_W]),
                            32'(want.count));
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_request(in_tuser[0], in_tdata));
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == CFG_IDX_ORDER) begin
        compare_signed = cfg_pwdata[0];
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the unsorted priority queue: a directed pass over
// the value extremes, empty and full queues and both compare orders, then
// random request phases, all but one with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
  import upq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_VALUE_W-1:0]   in_tdata;     // [31:0] value_in
  logic [0:0]              in_tuser;     // [0] req_type
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;    // [31:0] value_out, [36:32] entry_count
  logic [1:0]              out_tuser;    // [1:0] status
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CFG_ADDR_W-1:0]   cfg_paddr;
  logic [CFG_DATA_W-1:0]   cfg_pwdata;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  int errors;
  int pending;
  int checked;
  int sent_items  = 0;
  int cycle_count = 0;
  bit no_idle     = 1'b0;

  unsorted_priority_queue #(
    .DEPTH       (QUEUE_DEPTH),
    .VALUE_WIDTH (32)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  upq_checker #(
    .DEPTH (QUEUE_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: a random stall before each item, none while no_idle is set.
  initial begin
    int gap;
    out_tready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  task automatic send_item(input logic req, input logic [IN_VALUE_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= value;
    do @(posedge clk); while (in_tready !== 1'b1);
    sent_items++;
  endtask

  // Holds the request stream off until every result is back, then lets the
  // block settle.
  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_order(input logic order);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {CFG_IDX_ORDER, 2'b00};
    // Only bit 0 is meaningful; the rest carries noise.
    cfg_pwdata  <= {31'($urandom()), order};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Mix of full-range values, small values that tie often, extremes and
  // small negative numbers.
  function automatic logic [IN_VALUE_W-1:0] random_value();
    logic [IN_VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: v = $urandom_range(0, 7);
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      default: v = 32'hFFFF_FFF8 | $urandom_range(0, 7);
    endcase
    return v;
  endfunction

  task automatic run_phase(input logic order, input int enq_pct);
    logic req;
    wait_until_idle();
    write_order(order);
    repeat (PHASE_ITEMS) begin
      req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
      send_item(req, random_value());
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= REQ_ENQ;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unsigned order: empty dequeue, extremes and a tie on the largest value.
    write_order(1'b0);
    send_item(REQ_DEQ, 32'hFFFF_FFFF);
    send_item(REQ_ENQ, 32'h0000_0000);
    send_item(REQ_ENQ, 32'hFFFF_FFFF);
    send_item(REQ_ENQ, 32'h8000_0000);
    send_item(REQ_ENQ, 32'h7FFF_FFFF);
    send_item(REQ_ENQ, 32'h0000_0001);
    send_item(REQ_ENQ, 32'hFFFF_FFFF);
    repeat (3) send_item(REQ_DEQ, 32'h0000_0000);

    // Signed order: the positive extreme now wins, then fill past full.
    wait_until_idle();
    write_order(1'b1);
    send_item(REQ_ENQ, 32'h8000_0000);
    send_item(REQ_ENQ, 32'hFFFF_FFFF);
    repeat (2) send_item(REQ_DEQ, 32'h5555_AAAA);
    repeat (14) send_item(REQ_ENQ, random_value());

    run_phase(1'b0, 50);
    run_phase(1'b1, 70);
    no_idle = 1'b1;
    run_phase(1'b1, 30);
    no_idle = 1'b0;
    run_phase(1'b0, 60);
    run_phase(1'b1, 50);
    run_phase(1'($urandom_range(0, 1)), 55);

    wait_until_idle();
    repeat (40) @(posedge clk);
    $display("Sent %0d requests and checked %0d results in both compare orders,",
             sent_items, checked);
    $display("with empty and full queues and random stalls on both streams.");
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
